/* design/assert_macros.svh */
// Assertion macros for the geodetic conversion RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define G2E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that cons holds in the cycle after ante
`define G2E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/g2e_pkg.sv */
// Types, constants, tables and arithmetic helpers of the geodetic conversion.
// No dependencies; used by g2e_geo, geodetic_to_enu and the testbench.
package g2e_pkg;

	localparam int CORDIC_STAGES = 32;

	typedef logic signed [63:0] word_t;
	typedef logic signed [35:0] res_word_t;

	localparam word_t Q60_ONE    = 64'sh1000_0000_0000_0000;
	localparam word_t A_MM       = 64'sd6378137000;
	localparam word_t INV_PI_Q63 = 64'sh28BE_60DB_9391_054A;
	localparam logic [63:0] INVF_NUM = 64'd1000000000;
	localparam logic [63:0] INVF_DEN = 64'd298257223563;
	localparam int GAIN_NEWTON = 8;
	localparam word_t OUT_MAX = 64'sd34359738367;
	localparam word_t OUT_MIN = -64'sd34359738368;

	// configuration register indexes
	localparam logic [1:0] CFG_REF_LAT = 2'd0;
	localparam logic [1:0] CFG_REF_LON = 2'd1;
	localparam logic [1:0] CFG_REF_ALT = 2'd2;

	// exact product rounded to nearest, ties up, then shifted by s (elaboration only)
	function automatic word_t mulsh_c(word_t a, word_t b, int s);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = pa * pb;
		p = p + (128'sd1 <<< (s - 1));
		p = p >>> s;
		return p[63:0];
	endfunction

	function automatic word_t rsqrt_c(word_t w, word_t y0, int iters);
		word_t y;
		word_t t;
		y = y0;
		for (int k = 0; k < iters; k++) begin
			t = mulsh_c(w, mulsh_c(y, y, 60), 60);
			y = mulsh_c(y, 3 * Q60_ONE - t, 61);
		end
		return y;
	endfunction

	// restoring long division, elaboration only
	function automatic logic [63:0] udiv_c(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic word_t calc_e2();
		logic [63:0] r;
		logic [63:0] f;
		r = INVF_NUM;
		f = '0;
		for (int i = 0; i < 60; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= INVF_DEN) begin
				r = r - INVF_DEN;
				f[0] = 1'b1;
			end
		end
		return 2 * word_t'(f) - mulsh_c(word_t'(f), word_t'(f), 60);
	endfunction

	typedef word_t [CORDIC_STAGES-1:0] atan_tab_t;

	function automatic atan_tab_t calc_atan();
		atan_tab_t tab;
		word_t t;
		logic [63:0] term;
		tab[0] = 64'sd1 <<< 60;
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			t = '0;
			for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
				term = udiv_c(64'd1 << (62 - (2 * k + 1) * i), 64'(2 * k + 1));
				if (k % 2 == 1)
					t = t - word_t'(term);
				else
					t = t + word_t'(term);
			end
			tab[i] = mulsh_c(t, INV_PI_Q63, 63);
		end
		return tab;
	endfunction

	function automatic word_t calc_gain();
		word_t p;
		p = Q60_ONE;
		for (int i = 0; i < CORDIC_STAGES; i++)
			if (2 * i <= 62)
				p = p + (p >>> (2 * i));
		return rsqrt_c(p, 64'sd1 <<< 59, GAIN_NEWTON);
	endfunction

	localparam word_t     E2_Q60   = calc_e2();
	localparam word_t     B2A2_Q60 = Q60_ONE - E2_Q60;
	localparam word_t     GAIN_Q60 = calc_gain();
	localparam atan_tab_t ATAN_TAB = calc_atan();

	// split signed 64x64 product: three 33x33 and one 32x32 partial products
	typedef struct packed {
		logic signed [65:0] p11;
		logic signed [65:0] p10;
		logic signed [65:0] p01;
		logic [63:0] p00;
	} mul_pp_t;

	function automatic mul_pp_t mul_pp(word_t a, word_t b);
		logic signed [32:0] a1;
		logic signed [32:0] a0;
		logic signed [32:0] b1;
		logic signed [32:0] b0;
		mul_pp_t r;
		a1 = {a[63], a[63:32]};
		a0 = {1'b0, a[31:0]};
		b1 = {b[63], b[63:32]};
		b0 = {1'b0, b[31:0]};
		r.p11 = a1 * b1;
		r.p10 = a1 * b0;
		r.p01 = a0 * b1;
		r.p00 = a[31:0] * b[31:0];
		return r;
	endfunction

	function automatic word_t mul_fin(mul_pp_t p, int sh);
		logic [127:0] acc;
		acc = {p.p11[63:0], p.p00}
			+ {{30{p.p10[65]}}, p.p10, 32'd0}
			+ {{30{p.p01[65]}}, p.p01, 32'd0}
			+ (128'd1 << (sh - 1));
		acc = acc >> sh;
		return acc[63:0];
	endfunction

	// round millimetres times 2^16 to millimetres and clamp
	function automatic res_word_t sat36(word_t q);
		word_t v;
		v = (q + 64'sd32768) >>> 16;
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return v[35:0];
	endfunction

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} cordic_t;

	function automatic cordic_t cordic_step(cordic_t c, int i);
		cordic_t r;
		word_t dx;
		word_t dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (c.z >= 0) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - ATAN_TAB[i];
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + ATAN_TAB[i];
		end
		return r;
	endfunction

	typedef struct packed {
		word_t z;
		logic  flip;
	} ang_t;

	// fold into a half circle around zero and scale to 2^-62 semicircles
	function automatic ang_t reduce_ang(logic signed [31:0] ang);
		logic signed [32:0] a;
		word_t w;
		ang_t r;
		a = ang;
		r.flip = 1'b0;
		if (a > 33'sd1073741824) begin
			a = a - 33'sd2147483648;
			r.flip = 1'b1;
		end else if (a < -33'sd1073741824) begin
			a = a + 33'sd2147483648;
			r.flip = 1'b1;
		end
		w = a;
		r.z = w <<< 31;
		return r;
	endfunction

	typedef struct packed {
		cordic_t la;
		cordic_t lo;
		logic    fla;
		logic    flo;
		logic signed [31:0] alt;
	} cstage_t;

	// per-item working registers of the radius and ECEF sequence
	localparam int NREG = 18;
	localparam logic [4:0] R_SL    = 5'd0;
	localparam logic [4:0] R_CL    = 5'd1;
	localparam logic [4:0] R_SLO   = 5'd2;
	localparam logic [4:0] R_CLO   = 5'd3;
	localparam logic [4:0] R_H     = 5'd4;
	localparam logic [4:0] R_W     = 5'd5;
	localparam logic [4:0] R_Y     = 5'd6;
	localparam logic [4:0] R_T     = 5'd7;
	localparam logic [4:0] R_N     = 5'd8;
	localparam logic [4:0] R_U     = 5'd9;
	localparam logic [4:0] R_EX    = 5'd10;
	localparam logic [4:0] R_EY    = 5'd11;
	localparam logic [4:0] R_EZ    = 5'd12;
	localparam logic [4:0] R_E2    = 5'd13;
	localparam logic [4:0] R_AMM   = 5'd14;
	localparam logic [4:0] R_B2A2  = 5'd15;
	localparam logic [4:0] R_ONE   = 5'd16;
	localparam logic [4:0] R_THREE = 5'd17;

	typedef word_t [NREG-1:0] regs_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] a;
		logic [4:0] b;
		logic [4:0] d;
		logic [6:0] sh;
	} prog_t;

	localparam int NOPS = 31;

	localparam prog_t PROG [NOPS] = '{
		'{OP_MUL, R_SL,    R_SL,   R_T,  7'd60},
		'{OP_MUL, R_E2,    R_T,    R_T,  7'd60},
		'{OP_SUB, R_ONE,   R_T,    R_W,  7'd0},
		'{OP_MUL, R_Y,     R_Y,    R_T,  7'd60},
		'{OP_MUL, R_W,     R_T,    R_T,  7'd60},
		'{OP_SUB, R_THREE, R_T,    R_T,  7'd0},
		'{OP_MUL, R_Y,     R_T,    R_Y,  7'd61},
		'{OP_MUL, R_Y,     R_Y,    R_T,  7'd60},
		'{OP_MUL, R_W,     R_T,    R_T,  7'd60},
		'{OP_SUB, R_THREE, R_T,    R_T,  7'd0},
		'{OP_MUL, R_Y,     R_T,    R_Y,  7'd61},
		'{OP_MUL, R_Y,     R_Y,    R_T,  7'd60},
		'{OP_MUL, R_W,     R_T,    R_T,  7'd60},
		'{OP_SUB, R_THREE, R_T,    R_T,  7'd0},
		'{OP_MUL, R_Y,     R_T,    R_Y,  7'd61},
		'{OP_MUL, R_Y,     R_Y,    R_T,  7'd60},
		'{OP_MUL, R_W,     R_T,    R_T,  7'd60},
		'{OP_SUB, R_THREE, R_T,    R_T,  7'd0},
		'{OP_MUL, R_Y,     R_T,    R_Y,  7'd61},
		'{OP_MUL, R_Y,     R_Y,    R_T,  7'd60},
		'{OP_MUL, R_W,     R_T,    R_T,  7'd60},
		'{OP_SUB, R_THREE, R_T,    R_T,  7'd0},
		'{OP_MUL, R_Y,     R_T,    R_Y,  7'd61},
		'{OP_MUL, R_AMM,   R_Y,    R_N,  7'd44},
		'{OP_ADD, R_N,     R_H,    R_T,  7'd0},
		'{OP_MUL, R_T,     R_CL,   R_T,  7'd60},
		'{OP_MUL, R_T,     R_CLO,  R_EX, 7'd60},
		'{OP_MUL, R_T,     R_SLO,  R_EY, 7'd60},
		'{OP_MUL, R_N,     R_B2A2, R_U,  7'd60},
		'{OP_ADD, R_U,     R_H,    R_U,  7'd0},
		'{OP_MUL, R_U,     R_SL,   R_EZ, 7'd60}
	};

	localparam int GEO_DEPTH = CORDIC_STAGES + 2 + 2 * NOPS;

	typedef struct packed {
		word_t sl;
		word_t cl;
		word_t slo;
		word_t clo;
		word_t ex;
		word_t ey;
		word_t ez;
	} geo_t;

endpackage

/* design/g2e_geo.sv */
// Geodetic point to ECEF pipeline: CORDIC sine and cosine, radius, coordinates.
// Depends on g2e_pkg.
module g2e_geo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  latitude,
	input  logic signed [31:0]  longitude,
	input  logic signed [31:0]  altitude,
	output logic                out_valid,
	output g2e_pkg::geo_t       geo
);
	import g2e_pkg::*;

	logic [GEO_DEPTH-1:0] vld_s;
	cstage_t cord_s [CORDIC_STAGES+1];
	regs_t   st_s [NOPS+1];
	regs_t   ld;
	ang_t    ang_la;
	ang_t    ang_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[GEO_DEPTH-2:0], in_valid};
	end

	assign out_valid = vld_s[GEO_DEPTH-1];

	assign ang_la = reduce_ang(latitude);
	assign ang_lo = reduce_ang(longitude);

	always_ff @(posedge clk) begin
		if (en) begin
			cord_s[0].la  <= '{x: GAIN_Q60, y: '0, z: ang_la.z};
			cord_s[0].lo  <= '{x: GAIN_Q60, y: '0, z: ang_lo.z};
			cord_s[0].fla <= ang_la.flip;
			cord_s[0].flo <= ang_lo.flip;
			cord_s[0].alt <= altitude;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				cord_s[i+1].la  <= cordic_step(cord_s[i].la, i);
				cord_s[i+1].lo  <= cordic_step(cord_s[i].lo, i);
				cord_s[i+1].fla <= cord_s[i].fla;
				cord_s[i+1].flo <= cord_s[i].flo;
				cord_s[i+1].alt <= cord_s[i].alt;
			end
		end
	end

	always_comb begin
		ld          = '0;
		ld[R_SL]    = cord_s[CORDIC_STAGES].fla ? -cord_s[CORDIC_STAGES].la.y
			: cord_s[CORDIC_STAGES].la.y;
		ld[R_CL]    = cord_s[CORDIC_STAGES].fla ? -cord_s[CORDIC_STAGES].la.x
			: cord_s[CORDIC_STAGES].la.x;
		ld[R_SLO]   = cord_s[CORDIC_STAGES].flo ? -cord_s[CORDIC_STAGES].lo.y
			: cord_s[CORDIC_STAGES].lo.y;
		ld[R_CLO]   = cord_s[CORDIC_STAGES].flo ? -cord_s[CORDIC_STAGES].lo.x
			: cord_s[CORDIC_STAGES].lo.x;
		ld[R_H]     = word_t'(cord_s[CORDIC_STAGES].alt) <<< 16;
		ld[R_Y]     = Q60_ONE;
		ld[R_E2]    = E2_Q60;
		ld[R_AMM]   = A_MM;
		ld[R_B2A2]  = B2A2_Q60;
		ld[R_ONE]   = Q60_ONE;
		ld[R_THREE] = 3 * Q60_ONE;
	end

	always_ff @(posedge clk) begin
		if (en)
			st_s[0] <= ld;
	end

	for (genvar j = 0; j < NOPS; j++) begin : g_op
		localparam prog_t P = PROG[j];
		regs_t ra_s;

		if (P.op == OP_MUL) begin : g_mul
			mul_pp_t pp_s;
			regs_t   nxt;
			always_ff @(posedge clk) begin
				if (en) begin
					ra_s <= st_s[j];
					pp_s <= mul_pp(st_s[j][P.a], st_s[j][P.b]);
				end
			end
			always_comb begin
				nxt      = ra_s;
				nxt[P.d] = mul_fin(pp_s, int'(P.sh));
			end
			always_ff @(posedge clk) begin
				if (en)
					st_s[j+1] <= nxt;
			end
		end else begin : g_add
			word_t res_s;
			regs_t nxt;
			always_ff @(posedge clk) begin
				if (en) begin
					ra_s  <= st_s[j];
					res_s <= (P.op == OP_ADD) ? st_s[j][P.a] + st_s[j][P.b]
						: st_s[j][P.a] - st_s[j][P.b];
				end
			end
			always_comb begin
				nxt      = ra_s;
				nxt[P.d] = res_s;
			end
			always_ff @(posedge clk) begin
				if (en)
					st_s[j+1] <= nxt;
			end
		end
	end

	assign geo.sl  = st_s[NOPS][R_SL];
	assign geo.cl  = st_s[NOPS][R_CL];
	assign geo.slo = st_s[NOPS][R_SLO];
	assign geo.clo = st_s[NOPS][R_CLO];
	assign geo.ex  = st_s[NOPS][R_EX];
	assign geo.ey  = st_s[NOPS][R_EY];
	assign geo.ez  = st_s[NOPS][R_EZ];

endmodule

/* design/geodetic_to_enu.sv */
// Top level: WGS-84 geodetic point to ECEF and east-north-up from a reference.
// Depends on g2e_pkg, g2e_geo and assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_stall    | latitude, longitude, altitude
//  out      | out_valid / out_stall  | ecef_x, ecef_y, ecef_z, east, north, up
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle while in_stall is low. Registers from input to output: an
// angle rank, 32 CORDIC ranks, a load rank, the radius and coordinate sequence of 31
// two-rank steps, five ENU ranks and the output register.
// A second conversion pipeline runs the reference point alongside each request.
// Reset clears valid bits and the reference registers; no clearing pass.
// A stalled output spills into one skid entry; in_stall rises only when it is full.
`include "assert_macros.svh"

module geodetic_to_enu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  latitude,
	input  logic signed [31:0]  longitude,
	input  logic signed [31:0]  altitude,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [35:0]  ecef_x,
	output logic signed [35:0]  ecef_y,
	output logic signed [35:0]  ecef_z,
	output logic signed [35:0]  east,
	output logic signed [35:0]  north,
	output logic signed [35:0]  up,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import g2e_pkg::*;

	typedef res_word_t [5:0] res_t;
	typedef word_t [2:0] vec3_t;
	typedef word_t [3:0] vec4_t;
	typedef mul_pp_t [3:0] pp4_t;

	logic signed [31:0] ref_lat_q;
	logic signed [31:0] ref_lon_q;
	logic signed [31:0] ref_alt_q;

	logic en;
	logic vp;
	logic vr;
	geo_t gp;
	geo_t gr;

	logic [5:1] ve_s;
	vec3_t d_s1, d_s2, p_s1, p_s2, p_s3, p_s4, p_s5;
	vec4_t rt_s1, m_s2, a_s3, a_s4, g_s4;
	vec3_t enu_s5;
	pp4_t  pp_s1, pp_s2, pp_s3;

	res_t res_new;
	res_t res_q;
	res_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic take;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			ref_alt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REF_LAT: ref_lat_q <= cfg_data;
				CFG_REF_LON: ref_lon_q <= cfg_data;
				CFG_REF_ALT: ref_alt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	g2e_geo u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.latitude  (latitude),
		.longitude (longitude),
		.altitude  (altitude),
		.out_valid (vp),
		.geo       (gp)
	);

	g2e_geo u_ref (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.latitude  (ref_lat_q),
		.longitude (ref_lon_q),
		.altitude  (ref_alt_q),
		.out_valid (vr),
		.geo       (gr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ve_s <= '0;
		else if (en)
			ve_s <= {ve_s[4:1], vp};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// difference and reference rotation products
			p_s1  <= '{gp.ez, gp.ey, gp.ex};
			d_s1  <= '{gp.ez - gr.ez, gp.ey - gr.ey, gp.ex - gr.ex};
			rt_s1 <= '{gr.clo, gr.slo, gr.cl, gr.sl};
			pp_s1 <= '{mul_pp(gr.slo, gr.cl), mul_pp(gr.clo, gr.cl),
				mul_pp(gr.slo, gr.sl), mul_pp(gr.clo, gr.sl)};

			p_s2  <= p_s1;
			d_s2  <= d_s1;
			m_s2  <= '{mul_fin(pp_s1[3], 60), mul_fin(pp_s1[2], 60),
				mul_fin(pp_s1[1], 60), mul_fin(pp_s1[0], 60)};
			pp_s2 <= '{mul_pp(rt_s1[0], d_s1[2]), mul_pp(rt_s1[1], d_s1[2]),
				mul_pp(rt_s1[3], d_s1[1]), mul_pp(rt_s1[2], d_s1[0])};

			p_s3  <= p_s2;
			a_s3  <= '{mul_fin(pp_s2[3], 60), mul_fin(pp_s2[2], 60),
				mul_fin(pp_s2[1], 60), mul_fin(pp_s2[0], 60)};
			pp_s3 <= '{mul_pp(m_s2[3], d_s2[1]), mul_pp(m_s2[2], d_s2[0]),
				mul_pp(m_s2[1], d_s2[1]), mul_pp(m_s2[0], d_s2[0])};

			p_s4  <= p_s3;
			a_s4  <= a_s3;
			g_s4  <= '{mul_fin(pp_s3[3], 60), mul_fin(pp_s3[2], 60),
				mul_fin(pp_s3[1], 60), mul_fin(pp_s3[0], 60)};

			p_s5      <= p_s4;
			enu_s5[0] <= a_s4[1] - a_s4[0];
			enu_s5[1] <= a_s4[2] - g_s4[0] - g_s4[1];
			enu_s5[2] <= g_s4[2] + g_s4[3] + a_s4[3];
		end
	end

	assign res_new = '{sat36(enu_s5[2]), sat36(enu_s5[1]), sat36(enu_s5[0]),
		sat36(p_s5[2]), sat36(p_s5[1]), sat36(p_s5[0])};

	assign take = out_v_q && !out_stall;
	assign push = en && ve_s[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q  <= take ? (skid_v_q || push) : (out_v_q || push);
			skid_v_q <= take ? 1'b0 : (skid_v_q || (push && out_v_q));
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_v_q)
			res_q <= skid_q;
		else if (push && (take || !out_v_q))
			res_q <= res_new;
		if (push && out_v_q && !take)
			skid_q <= res_new;
	end

	assign out_valid = out_v_q;
	assign ecef_x    = res_q[0];
	assign ecef_y    = res_q[1];
	assign ecef_z    = res_q[2];
	assign east      = res_q[3];
	assign north     = res_q[4];
	assign up        = res_q[5];

	`G2E_ASSERT(a_ref_lockstep, vp == vr, "reference pipeline out of step")
	`G2E_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid entry without output")
	`G2E_ASSERT_NEXT(a_spill_to_skid, push && out_v_q && !take, skid_v_q, "result dropped")

endmodule

/* sim/tb_geodetic_to_enu.sv */
// Testbench for geodetic_to_enu: drives geodetic points under random idling and
// back-pressure, predicts ECEF and east-north-up results in fixed point and checks them.
// Depends on g2e_pkg and the geodetic_to_enu RTL.
module tb_geodetic_to_enu;
	timeunit 1ns;
	timeprecision 1ps;
	import g2e_pkg::*;

	typedef logic signed [63:0] q_t;
	typedef logic signed [35:0] mm_t;

	typedef struct {
		mm_t x;
		mm_t y;
		mm_t z;
		mm_t e;
		mm_t n;
		mm_t u;
	} enu_fix_t;

	typedef struct {
		q_t sla;
		q_t cla;
		q_t slo;
		q_t clo;
		q_t px;
		q_t py;
		q_t pz;
	} ecef_t;

	localparam int NSTAGE = 32;
	localparam q_t ONE_Q60 = 64'sh1000_0000_0000_0000;
	localparam q_t SEMI_MAJOR_MM = 64'sd6378137000;
	localparam q_t INV_PI = 64'sh28BE_60DB_9391_054A;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int LAT_QUARTER = 1073741824;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] latitude = '0;
	logic signed [31:0] longitude = '0;
	logic signed [31:0] altitude = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mm_t ecef_x, ecef_y, ecef_z, east, north, up;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	q_t atan_q62 [NSTAGE];
	q_t cordic_gain;
	q_t ecc2;
	q_t one_minus_ecc2;
	logic signed [31:0] ref_lat_r, ref_lon_r, ref_alt_r;

	enu_fix_t pending_fixes [$];
	int errors = 0;
	int hold_cycles = 0;
	int stall_left = 0;
	bit rx_stalls = 1'b1;
	bit tx_gaps = 1'b1;

	always #4 clk = ~clk;

	geodetic_to_enu u_top (.*);

	function automatic q_t mul_round(q_t a, q_t b, int s);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = pa * pb + (128'sd1 <<< (s - 1));
		p = p >>> s;
		return p[63:0];
	endfunction

	function automatic q_t inv_sqrt(q_t w, q_t y0, int iters);
		q_t y;
		q_t t;
		y = y0;
		for (int k = 0; k < iters; k++) begin
			t = mul_round(w, mul_round(y, y, 60), 60);
			y = mul_round(y, 3 * ONE_Q60 - t, 61);
		end
		return y;
	endfunction

	task automatic build_constants();
		logic [63:0] rem;
		logic [63:0] fl;
		logic [63:0] term;
		q_t acc;
		q_t p;
		rem = 64'd1000000000;
		fl = '0;
		for (int i = 0; i < 60; i++) begin
			rem = rem << 1;
			fl = fl << 1;
			if (rem >= 64'd298257223563) begin
				rem = rem - 64'd298257223563;
				fl[0] = 1'b1;
			end
		end
		ecc2 = 2 * q_t'(fl) - mul_round(q_t'(fl), q_t'(fl), 60);
		one_minus_ecc2 = ONE_Q60 - ecc2;
		atan_q62[0] = 64'sd1 <<< 60;
		for (int i = 1; i < NSTAGE; i++) begin
			acc = '0;
			for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
				term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
				if (k % 2 == 1)
					acc = acc - q_t'(term);
				else
					acc = acc + q_t'(term);
			end
			atan_q62[i] = mul_round(acc, INV_PI, 63);
		end
		p = ONE_Q60;
		for (int i = 0; i < NSTAGE; i++)
			if (2 * i <= 62)
				p = p + (p >>> (2 * i));
		cordic_gain = inv_sqrt(p, 64'sd1 <<< 59, 8);
	endtask

	task automatic sin_cos(input logic signed [31:0] angle, output q_t sn, output q_t cs);
		q_t a;
		q_t x;
		q_t y;
		q_t z;
		q_t dx;
		q_t dy;
		bit flip;
		a = angle;
		flip = 1'b0;
		if (a > 64'sd1073741824) begin
			a = a - 64'sd2147483648;
			flip = 1'b1;
		end else if (a < -64'sd1073741824) begin
			a = a + 64'sd2147483648;
			flip = 1'b1;
		end
		x = cordic_gain;
		y = '0;
		z = a * 64'sd2147483648;
		for (int i = 0; i < NSTAGE; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_q62[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_q62[i];
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	task automatic to_ecef(input logic signed [31:0] lat, input logic signed [31:0] lon,
			input logic signed [31:0] alt, output ecef_t r);
		q_t w;
		q_t nrad;
		q_t h;
		q_t r1;
		sin_cos(lat, r.sla, r.cla);
		sin_cos(lon, r.slo, r.clo);
		w = ONE_Q60 - mul_round(ecc2, mul_round(r.sla, r.sla, 60), 60);
		nrad = mul_round(SEMI_MAJOR_MM, inv_sqrt(w, ONE_Q60, 5), 44);
		h = q_t'(alt) * 64'sd65536;
		r1 = nrad + h;
		r.px = mul_round(mul_round(r1, r.cla, 60), r.clo, 60);
		r.py = mul_round(mul_round(r1, r.cla, 60), r.slo, 60);
		r.pz = mul_round(mul_round(nrad, one_minus_ecc2, 60) + h, r.sla, 60);
	endtask

	function automatic mm_t round_sat(q_t q);
		q_t v;
		v = (q + 64'sd32768) >>> 16;
		if (v > 64'sd34359738367)
			v = 64'sd34359738367;
		if (v < -64'sd34359738368)
			v = -64'sd34359738368;
		return v[35:0];
	endfunction

	task automatic predict_fix(input logic signed [31:0] lat, input logic signed [31:0] lon,
			input logic signed [31:0] alt);
		ecef_t pt;
		ecef_t rf;
		q_t dx, dy, dz, e, n, u;
		enu_fix_t f;
		to_ecef(lat, lon, alt, pt);
		to_ecef(ref_lat_r, ref_lon_r, ref_alt_r, rf);
		dx = pt.px - rf.px;
		dy = pt.py - rf.py;
		dz = pt.pz - rf.pz;
		e = -mul_round(rf.slo, dx, 60) + mul_round(rf.clo, dy, 60);
		n = -mul_round(mul_round(rf.clo, rf.sla, 60), dx, 60)
			- mul_round(mul_round(rf.slo, rf.sla, 60), dy, 60)
			+ mul_round(rf.cla, dz, 60);
		u = mul_round(mul_round(rf.clo, rf.cla, 60), dx, 60)
			+ mul_round(mul_round(rf.slo, rf.cla, 60), dy, 60)
			+ mul_round(rf.sla, dz, 60);
		f.x = round_sat(pt.px);
		f.y = round_sat(pt.py);
		f.z = round_sat(pt.pz);
		f.e = round_sat(e);
		f.n = round_sat(n);
		f.u = round_sat(u);
		pending_fixes = {pending_fixes, f};
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (!tx_gaps || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic send_point(logic signed [31:0] lat, logic signed [31:0] lon,
			logic signed [31:0] alt);
		int g;
		in_valid <= 1'b1;
		latitude <= lat;
		longitude <= lon;
		altitude <= alt;
		do @(posedge clk); while (in_stall);
		predict_fix(lat, lon, alt);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_fixes.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_REF_LAT)
			ref_lat_r = val;
		else if (idx == CFG_REF_LON)
			ref_lon_r = val;
		else if (idx == CFG_REF_ALT)
			ref_alt_r = val;
	endtask

	task automatic set_reference(logic [31:0] lat, logic [31:0] lon, logic [31:0] alt);
		write_reg(CFG_REF_LAT, lat);
		write_reg(CFG_REF_LON, lon);
		write_reg(CFG_REF_ALT, alt);
	endtask

	function automatic logic [31:0] rand_lat();
		if ($urandom_range(9, 0) == 0)
			return $urandom;
		return 32'($urandom_range(32'h8000_0000, 0)) - 32'(LAT_QUARTER);
	endfunction

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_point(rand_lat(), $urandom, $urandom);
	endtask

	task automatic check_field(string name, mm_t exp_v, mm_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		enu_fix_t f;
		if (out_valid && !out_stall) begin
			if (pending_fixes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual ecef_x %0d",
					$time, ecef_x);
				errors++;
			end else begin
				f = pending_fixes.pop_front();
				check_field("ecef_x", f.x, ecef_x);
				check_field("ecef_y", f.y, ecef_y);
				check_field("ecef_z", f.z, ecef_z);
				check_field("east", f.e, east);
				check_field("north", f.n, north);
				check_field("up", f.u, up);
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_stalls && $urandom_range(3, 0) == 0) begin
			stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 5)
				: $urandom_range(2, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_directed();
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sd1073741824, 32'sd0, 32'sd0);
		send_point(-32'sd1073741824, 32'sd0, 32'sd0);
		send_point(32'sd1073741825, 32'sd1073741825, 32'sd1000);
		send_point(-32'sd1073741825, -32'sd1073741825, -32'sd1000);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sd1073741824, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(32'sd1500000000, 32'sd1073741824, 32'sd123456);
		send_point(-32'sd1500000000, -32'sd1073741824, -32'sd123456);
		send_point(32'sd536870912, 32'sd536870912, 32'sd0);
		send_point(32'sd1, -32'sd1, 32'sd1);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		drain();
	endtask

	task automatic test_reference_sweep();
		set_reference(32'sd1073741824, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_random(150);
		drain();
		set_reference(-32'sd1073741824, 32'sh8000_0000, 32'sh8000_0000);
		send_random(150);
		drain();
		set_reference(32'sd0, 32'sd1073741824, 32'sd0);
		send_random(100);
		drain();
		write_reg(CFG_UNUSED, $urandom);
		send_random(50);
		drain();
		for (int k = 0; k < 3; k++) begin
			set_reference(rand_lat(), $urandom, $urandom);
			send_random(100);
			drain();
		end
	endtask

	task automatic test_random_idling();
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		send_random(200);
		tx_gaps = 1'b1;
		send_random(200);
		rx_stalls = 1'b1;
		send_random(300);
		drain();
	endtask

	task automatic test_backpressure();
		tx_gaps = 1'b0;
		hold_cycles = 400;
		send_random(300);
		tx_gaps = 1'b1;
		drain();
	endtask

	task automatic test_sender_pause();
		send_random(60);
		drain();
		send_random(60);
		drain();
	endtask

	initial begin
		build_constants();
		ref_lat_r = '0;
		ref_lon_r = '0;
		ref_alt_r = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reference_sweep();
		test_random_idling();
		test_backpressure();
		test_sender_pause();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/g2e_pkg.sv
design/g2e_geo.sv
design/geodetic_to_enu.sv
sim/tb_geodetic_to_enu.sv
